// ----- src/firlp_pkg.sv -----
// shared constants, types and coefficient table for the 17-tap low-pass fir
package firlp_pkg;

  localparam int TAPS       = 17;
  localparam int COEF_COUNT = 17;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = 40;
  localparam int Q_SHIFT    = 15;

  // history entries; one spare entry keeps the line nonempty for a single tap
  localparam int DELAY_DEPTH = (TAPS > 1) ? TAPS - 1 : 1;
  localparam int DELAY_IDX_W = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int TAP_CNT_W   = $clog2(TAPS + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [TAP_CNT_W-1:0]       tap_cnt_t;

  localparam acc_t SAT_HI    = ACC_W'(32767);
  localparam acc_t SAT_LO    = -ACC_W'(32768);
  localparam acc_t ROUND_NEG = ACC_W'((2 ** Q_SHIFT) - 1);

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctrl_t;

  // q1.15 coefficients; taps past the table have weight zero
  function automatic coef_t coef_at(input tap_cnt_t k);
    coef_t c;
    case (int'(k))
      0:       c = -16'sd72;
      1:       c = 16'sd758;
      2:       c = 16'sd1127;
      3:       c = 16'sd1770;
      4:       c = 16'sd2494;
      5:       c = 16'sd3202;
      6:       c = 16'sd3799;
      7:       c = 16'sd4198;
      8:       c = 16'sd4338;
      9:       c = 16'sd4198;
      10:      c = 16'sd3799;
      11:      c = 16'sd3202;
      12:      c = 16'sd2494;
      13:      c = 16'sd1770;
      14:      c = 16'sd1127;
      15:      c = 16'sd758;
      16:      c = -16'sd72;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- src/fir_lowpass_17tap_unit.sv -----
// top level of the 17-tap symmetric low-pass fir for 16-bit audio
//
// usage:
//   input stream (s_tvalid / s_tready / s_tdata) carries one signed 16-bit
//   sample per transaction; output stream (m_tvalid / m_tready / m_tdata)
//   carries one signed 16-bit filtered sample per input sample, in order.
// sequencing:
//   one shared multiply-accumulate unit handles one tap per cycle; a
//   sample passes through the mac loop, one step per tap, and then the
//   truncate and saturate step, which writes the output register that
//   drives m_tvalid. a new sample is taken only after the last one has
//   finished, and only while the output side keeps up.
// reset:
//   rst (synchronous, active high) clears the 16-entry history to zeros,
//   empties the output register and returns the sequencer to idle.
// stall:
//   the finished result sits in the output register until taken; if an
//   older result still waits there, the next one holds in the final step
//   and the history is not shifted until it moves out. s_tready stays low
//   while a sample is in work.
module fir_lowpass_17tap_unit
  import firlp_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic signed [15:0] s_tdata,   // [15:0] sample_in
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic signed [15:0] m_tdata    // [15:0] sample_out
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAC  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  tap_cnt_t   tap;
  tap_cnt_t   tap_next;
  sample_t    x_cur;
  sample_t    delay_line [DELAY_DEPTH];

  mac_ctrl_t  mac_ctrl;
  coef_t      mac_coef;
  sample_t    mac_sample;
  acc_t       acc;

  logic [TAP_CNT_W-1:0]   tap_prev;
  logic [DELAY_IDX_W-1:0] hist_idx;
  acc_t                   biased;
  acc_t                   shifted;
  sample_t                y;

  logic in_take;
  logic out_free;
  logic finish;

  assign s_tready = (state == ST_IDLE);
  assign in_take  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign finish   = (state == ST_FIN) && out_free;

  // tap 0 is the new sample, tap k reads history entry k-1
  assign tap_prev   = tap - TAP_CNT_W'(1);
  assign hist_idx   = tap_prev[DELAY_IDX_W-1:0];
  assign mac_coef   = coef_at(tap);
  assign mac_sample = (tap == '0) ? x_cur : delay_line[hist_idx];

  assign mac_ctrl.clr = in_take;
  assign mac_ctrl.en  = (state == ST_MAC);

  firlp_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .coef   (mac_coef),
    .sample (mac_sample),
    .acc    (acc)
  );

  // truncate toward zero: bias negatives before the arithmetic shift
  always_comb begin
    biased  = acc + (acc[ACC_W-1] ? ROUND_NEG : '0);
    shifted = biased >>> Q_SHIFT;
    if (shifted > SAT_HI) begin
      y = SAMPLE_W'(SAT_HI);
    end else if (shifted < SAT_LO) begin
      y = SAMPLE_W'(SAT_LO);
    end else begin
      y = shifted[SAMPLE_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    tap_next   = tap;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          state_next = ST_MAC;
          tap_next   = '0;
        end
      end
      ST_MAC: begin
        tap_next = tap + TAP_CNT_W'(1);
        if (tap == TAP_CNT_W'(TAPS - 1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tap   <= '0;
    end else begin
      state <= state_next;
      tap   <= tap_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      x_cur <= s_tdata;
    end
  end

  // history shifts only once the result is committed
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DELAY_DEPTH; i++) begin
        delay_line[i] <= '0;
      end
    end else if (finish && (TAPS > 1)) begin
      for (int i = DELAY_DEPTH - 1; i > 0; i--) begin
        delay_line[i] <= delay_line[i-1];
      end
      delay_line[0] <= x_cur;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata <= y;
    end
  end

endmodule

// ----- src/firlp_mac.sv -----
// shared multiply-accumulate unit with a 40-bit exact accumulator
module firlp_mac
  import firlp_pkg::*;
(
  input  logic      clk,
  input  mac_ctrl_t ctrl,
  input  coef_t     coef,
  input  sample_t   sample,
  output acc_t      acc
);

  prod_t prod;
  acc_t  acc_next;

  assign prod = coef * sample;

  always_comb begin
    acc_next = acc;
    if (ctrl.clr) begin
      acc_next = '0;
    end else if (ctrl.en) begin
      acc_next = acc + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

endmodule

// ----- tb/tb.sv -----
// testbench for the 17-tap low-pass fir: table-driven start, then random bursts vs a predictor
`timescale 1ns / 1ps

module tb;
  import firlp_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1950;
  localparam int SETTLE       = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int ERR_PRINT    = 50;
  localparam int HIST_DEPTH   = 16;
  localparam sample_t FULL_POS = 16'sh7FFF;
  localparam sample_t FULL_NEG = -16'sh8000;

  // q1.15 weights of the symmetric low-pass response
  localparam int WEIGHT [17] = '{
    -72, 758, 1127, 1770, 2494, 3202, 3799, 4198, 4338,
    4198, 3799, 3202, 2494, 1770, 1127, 758, -72
  };

  typedef struct {
    sample_t din;
    bit      has_want;
    sample_t want;
  } stim_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    s_tvalid = 1'b0;
  logic    s_tready;
  sample_t s_tdata = '0;
  logic    m_tvalid;
  logic    m_tready = 1'b0;
  logic signed [15:0] m_tdata;

  sample_t   filter_history [HIST_DEPTH];
  sample_t   filtered_due [$];
  stim_row_t sample_table [$];
  bit        cur_has_want = 1'b0;
  sample_t   cur_want = '0;
  bit        calm = 1'b0;
  int        fails = 0;
  int        samples_in = 0;
  int        results_seen = 0;
  int        clipped_hi = 0;
  int        clipped_lo = 0;
  int        cycle_count = 0;

  fir_lowpass_17tap_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic bit idle_roll();
    return !calm && ($urandom_range(99) < 24);
  endfunction

  // exact sum, truncate toward zero, clamp; then shift the history
  function automatic sample_t predict_filtered(input sample_t x);
    longint acc;
    longint y;
    acc = longint'(WEIGHT[0]) * longint'(x);
    for (int k = 1; k < 17; k++) begin
      acc += longint'(WEIGHT[k]) * longint'(filter_history[k-1]);
    end
    if (acc < 0) begin
      y = -((-acc) >>> 15);
    end else begin
      y = acc >>> 15;
    end
    if (y > 32767) begin
      y = 32767;
      clipped_hi++;
    end
    if (y < -32768) begin
      y = -32768;
      clipped_lo++;
    end
    for (int k = HIST_DEPTH - 1; k > 0; k--) begin
      filter_history[k] = filter_history[k-1];
    end
    filter_history[0] = x;
    return sample_t'(y);
  endfunction

  task automatic add_row(input sample_t din, input bit has_want, input sample_t want);
    stim_row_t r;
    r.din = din;
    r.has_want = has_want;
    r.want = want;
    sample_table.push_back(r);
  endtask

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_sample(input sample_t x);
    while (idle_roll()) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // hold the input off until every outstanding result has come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (filtered_due.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    m_tready <= rst ? 1'b0 : !idle_roll();
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin : scoreboard
    sample_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (filtered_due.size() == 0) begin
          fails++;
          if (fails <= ERR_PRINT) $error("sample_out: no result expected, actual %0d", m_tdata);
        end else begin
          want = filtered_due.pop_front();
          if (m_tdata !== want) begin
            fails++;
            if (fails <= ERR_PRINT)
              $error("sample_out: expected %0d, actual %0d", want, m_tdata);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        samples_in++;
        want = predict_filtered(s_tdata);
        filtered_due.push_back(cur_has_want ? cur_want : want);
      end
    end
  end

  initial begin : stimulus
    sample_t burst [$];
    int      sent_random;
    int      mode;
    int      len;
    int      walk;
    bit      pressed;
    bit      neg;

    for (int k = 0; k < HIST_DEPTH; k++) filter_history[k] = '0;

    // fresh history: only the newest tap counts, and truncation goes toward zero
    add_row(FULL_POS, 1'b1, -16'sd71);
    for (int k = 0; k < 15; k++) add_row(FULL_POS, 1'b0, '0);
    // window full of full-scale positive samples clips high
    add_row(FULL_POS, 1'b1, FULL_POS);
    for (int k = 0; k < 4; k++) add_row(FULL_NEG, 1'b0, '0);
    add_row(16'sd1, 1'b0, '0);
    add_row(-16'sd1, 1'b0, '0);
    add_row(16'sd0, 1'b0, '0);
    add_row(-16'sd2, 1'b0, '0);

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (sample_table[i]) begin
      cur_has_want = sample_table[i].has_want;
      cur_want     = sample_table[i].want;
      send_sample(sample_table[i].din);
    end
    cur_has_want = 1'b0;
    drain_results();

    sent_random = 0;
    pressed = 1'b0;
    while (sent_random < RANDOM_ITEMS) begin
      burst.delete();
      mode = $urandom_range(5);
      neg  = 1'($urandom_range(1));
      case (mode)
        0: begin
          len = $urandom_range(30, 5);
          repeat (len) burst.push_back(sample_t'($urandom));
        end
        1: begin
          // long constant full-scale run drives the output into the clamp
          len = $urandom_range(30, 17);
          repeat (len) burst.push_back(neg ? FULL_NEG : FULL_POS);
        end
        2: begin
          // worst-case window: outer taps against the fifteen inner ones
          burst.push_back(neg ? FULL_POS : FULL_NEG);
          repeat (15) burst.push_back(neg ? FULL_NEG : FULL_POS);
          burst.push_back(neg ? FULL_POS : FULL_NEG);
        end
        3: begin
          len = $urandom_range(30, 5);
          repeat (len) burst.push_back(sample_t'(int'($urandom_range(511)) - 256));
        end
        4: begin
          // alternating sign: full-scale negative samples between random positive ones
          len = $urandom_range(30, 10);
          for (int k = 0; k < len; k++) begin
            burst.push_back(((k % 2) != 0) ^ neg ? FULL_NEG : sample_t'($urandom_range(32767)));
          end
        end
        default: begin
          len = $urandom_range(40, 10);
          walk = int'(sample_t'($urandom));
          repeat (len) begin
            walk += int'($urandom_range(4000)) - 2000;
            if (walk > 32767) walk = 32767;
            if (walk < -32768) walk = -32768;
            burst.push_back(sample_t'(walk));
          end
        end
      endcase
      foreach (burst[i]) begin
        calm = (sent_random >= 700) && (sent_random < 1000);
        send_sample(burst[i]);
        sent_random++;
      end
      if (!pressed && sent_random >= 1300) begin
        pressed = 1'b1;
        drain_results();
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (SETTLE) @(negedge clk);

    $display("run covered %0d samples and %0d filtered results", samples_in, results_seen);
    $display("clamp hits: %0d high, %0d low", clipped_hi, clipped_lo);
    if (fails == 0 && filtered_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- fir_lowpass_17tap_unit.f -----
src/firlp_pkg.sv
src/firlp_mac.sv
src/fir_lowpass_17tap_unit.sv
tb/tb.sv
